/* hdl/ptts_pkg.sv */
// shared types and constants of the periodic task tick scheduler
`default_nettype none

package ptts_pkg;

  // request codes on the input channel
  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SUSPEND = 3'd2,
    REQ_RESUME  = 3'd3,
    REQ_TICK    = 3'd4
  } req_type_t;

  // result status codes
  typedef enum logic [3:0] {
    STAT_CREATED   = 4'd0,
    STAT_RESERVED  = 4'd1,
    STAT_BAD_SLOT  = 4'd2,
    STAT_DELETED   = 4'd3,
    STAT_NOT_EXIST = 4'd4,
    STAT_SUSPENDED = 4'd5,
    STAT_RESUMED   = 4'd6,
    STAT_FIRED     = 4'd7,
    STAT_IDLE      = 4'd8
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_WALK,
    CTL_FLUSH
  } ctl_state_t;

  // at most this many fired results are reported per tick
  localparam int MAX_FIRES  = 8;
  localparam int FIRE_CNT_W = 4;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch the incoming request, arm the walk
    logic exec;    // run a single-slot request and load its result
    logic walk;    // advance the tick walk
    logic flush;   // load the closing result of a tick
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req_type;   // type of the request on the input channel
    logic       out_free;   // output register can take a result this cycle
    logic       walk_done;  // every slot has been visited
  } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/ptts_in_if.sv */
// request channel of the scheduler
`default_nettype none

interface ptts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] slot;
  logic [7:0] period;
  logic [7:0] first_delay;

  modport source (output valid, req_type, slot, period, first_delay, input ready);
  modport sink (input valid, req_type, slot, period, first_delay, output ready);
endinterface

`default_nettype wire

/* hdl/ptts_out_if.sv */
// result channel of the scheduler
`default_nettype none

interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [2:0] task_index;
  logic       last;

  modport source (output valid, status, task_index, last, input ready);
  modport sink (input valid, status, task_index, last, output ready);
endinterface

`default_nettype wire

/* hdl/ptts_datapath.sv */
// slot table, tick walk pipeline and result register of the scheduler
`default_nettype none

module ptts_datapath #(
  parameter int NUM_TASKS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ptts_pkg::dp_cmd_t cmd,
  output ptts_pkg::dp_sts_t      sts,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [7:0]        in_slot,
  input  wire logic [7:0]        in_period,
  input  wire logic [7:0]        in_first_delay,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_status,
  output logic [2:0]             out_task_index,
  output logic                   out_last
);
  import ptts_pkg::*;

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);

  // slot state
  logic [NUM_TASKS-1:0] valid_r, valid_nxt;
  logic [NUM_TASKS-1:0] running_r, running_nxt;
  logic [15:0]          mem [NUM_TASKS];  // {period, countdown}

  // latched request
  logic [2:0] req_r;
  logic [7:0] slot_r, period_r, fd_r;

  // walk pipeline
  logic [CW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic                  p1_vld_r, p1_vld_nxt;
  logic [IW-1:0]         p1_idx_r, p1_idx_nxt;
  logic [7:0]            rd_per_r, rd_cd_r;
  logic [FIRE_CNT_W-1:0] fire_cnt_r, fire_cnt_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [2:0]            pend_idx_r, pend_idx_nxt;

  // result register
  logic       out_vld_r, out_vld_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [2:0] out_idx_r, out_idx_nxt;
  logic       out_last_r, out_last_nxt;

  logic          in_range, hit, out_free;
  logic [IW-1:0] sidx;
  logic [2:0]    req_idx;
  status_t       exec_status;
  logic          act, fire, report, push, stall, step, rd_en;
  logic [7:0]    p1_idx8;
  logic [2:0]    fire_idx;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [15:0]   wr_data;

  assign out_free = !out_vld_r || out_ready;

  assign in_range = slot_r < 8'(NUM_TASKS);
  assign sidx     = slot_r[IW-1:0];
  assign hit      = in_range && valid_r[sidx];
  assign req_idx  = in_range ? slot_r[2:0] : 3'd0;

  // single-slot requests
  always_comb begin
    exec_status = STAT_NOT_EXIST;
    valid_nxt   = valid_r;
    running_nxt = running_r;
    unique case (req_r)
      REQ_CREATE: begin
        if (!in_range) begin
          exec_status = STAT_BAD_SLOT;
        end else if (hit) begin
          exec_status = STAT_RESERVED;
        end else begin
          exec_status = STAT_CREATED;
          if (cmd.exec) begin
            valid_nxt[sidx]   = 1'b1;
            running_nxt[sidx] = 1'b1;
          end
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          exec_status = STAT_DELETED;
          if (cmd.exec) begin
            valid_nxt[sidx]   = 1'b0;
            running_nxt[sidx] = 1'b0;
          end
        end
      end
      REQ_SUSPEND: begin
        if (hit) begin
          exec_status = STAT_SUSPENDED;
          if (cmd.exec) begin
            running_nxt[sidx] = 1'b0;
          end
        end
      end
      REQ_RESUME: begin
        if (hit) begin
          exec_status = STAT_RESUMED;
          if (cmd.exec) begin
            running_nxt[sidx] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // tick walk: stage 0 reads slot rd_ptr, stage 1 updates slot p1_idx
  assign p1_idx8  = 8'(p1_idx_r);
  assign fire_idx = p1_idx8[2:0];
  assign act      = p1_vld_r && valid_r[p1_idx_r] && running_r[p1_idx_r];
  assign fire     = act && (rd_cd_r == 8'd0);
  assign report   = fire && (fire_cnt_r < FIRE_CNT_W'(MAX_FIRES));
  assign push     = report && pend_vld_r;
  assign stall    = push && !out_free;
  assign step     = cmd.walk && !stall;
  assign rd_en    = step && (rd_ptr_r != CW'(NUM_TASKS));

  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    p1_vld_nxt   = p1_vld_r;
    p1_idx_nxt   = p1_idx_r;
    fire_cnt_nxt = fire_cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    if (cmd.accept) begin
      rd_ptr_nxt   = '0;
      p1_vld_nxt   = 1'b0;
      fire_cnt_nxt = '0;
      pend_vld_nxt = 1'b0;
    end else if (step) begin
      p1_vld_nxt = rd_en;
      p1_idx_nxt = rd_ptr_r[IW-1:0];
      if (rd_en) begin
        rd_ptr_nxt = rd_ptr_r + CW'(1);
      end
      if (report) begin
        pend_vld_nxt = 1'b1;
        pend_idx_nxt = fire_idx;
        fire_cnt_nxt = fire_cnt_r + FIRE_CNT_W'(1);
      end
    end else if (cmd.flush) begin
      pend_vld_nxt = 1'b0;
    end
  end

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p1_idx_r;
    wr_data = {rd_per_r, fire ? rd_per_r : rd_cd_r - 8'd1};
    if (cmd.exec && req_r == REQ_CREATE && in_range && !valid_r[sidx]) begin
      wr_en   = 1'b1;
      wr_addr = sidx;
      wr_data = {period_r, fd_r};
    end else if (step && act) begin
      wr_en = 1'b1;
    end
  end

  // result register
  always_comb begin
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    if (cmd.exec) begin
      out_vld_nxt    = 1'b1;
      out_status_nxt = exec_status;
      out_idx_nxt    = req_idx;
      out_last_nxt   = 1'b1;
    end else if (step && push) begin
      out_vld_nxt    = 1'b1;
      out_status_nxt = STAT_FIRED;
      out_idx_nxt    = pend_idx_r;
      out_last_nxt   = 1'b0;
    end else if (cmd.flush) begin
      out_vld_nxt    = 1'b1;
      out_status_nxt = pend_vld_r ? STAT_FIRED : STAT_IDLE;
      out_idx_nxt    = pend_vld_r ? pend_idx_r : 3'd0;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      {rd_per_r, rd_cd_r} <= mem[rd_ptr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_req_type;
      slot_r   <= in_slot;
      period_r <= in_period;
      fd_r     <= in_first_delay;
    end
    p1_idx_r     <= p1_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      running_r  <= '0;
      rd_ptr_r   <= '0;
      p1_vld_r   <= 1'b0;
      fire_cnt_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      running_r  <= running_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      p1_vld_r   <= p1_vld_nxt;
      fire_cnt_r <= fire_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign sts.req_type  = in_req_type;
  assign sts.out_free  = out_free;
  assign sts.walk_done = (rd_ptr_r == CW'(NUM_TASKS)) && !p1_vld_r;

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_task_index = out_idx_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* hdl/ptts_ctrl.sv */
// request sequencer of the scheduler
`default_nettype none

module ptts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptts_pkg::dp_sts_t sts,
  output ptts_pkg::dp_cmd_t      cmd
);
  import ptts_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      CTL_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          unique case (sts.req_type) inside
            REQ_CREATE, REQ_DELETE, REQ_SUSPEND, REQ_RESUME: state_nxt = CTL_EXEC;
            REQ_TICK: state_nxt = CTL_WALK;
            default: state_nxt = CTL_IDLE;
          endcase
        end
      end
      CTL_EXEC: begin
        cmd.exec = sts.out_free;
        if (sts.out_free) begin
          state_nxt = CTL_IDLE;
        end
      end
      CTL_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = CTL_FLUSH;
        end
      end
      CTL_FLUSH: begin
        cmd.flush = sts.out_free;
        if (sts.out_free) begin
          state_nxt = CTL_IDLE;
        end
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/periodic_task_tick_scheduler.sv */
// top level of the periodic task tick scheduler
`default_nettype none

// Cooperative periodic task scheduler with NUM_TASKS slots, slot number equal
// to priority. Each request carries a type: create fills a free slot with a
// reload period and a first delay and starts it, delete frees a slot, suspend
// and resume stop and restart its countdown; each of these answers with one
// status result whose last flag is set. A tick request walks the slots from 0
// upward: a valid running slot whose countdown is zero fires and reloads its
// period, other valid running slots count down by one. The tick answers with
// one fired result per firing (at most eight; later firings still reload but
// are not reported), last set on the final one, or a single idle result when
// nothing fired. Request types 5 to 7 are dropped without a result. The fired
// task index and the request slot are reported in three bits.
// One request is handled at a time. Create, delete, suspend and resume load
// their result in the execute state once the result register is free, then
// return to idle for the next request. A tick walks the slots, then loads its
// final result in the flush state and returns to idle: the period and
// countdown table is a memory with one read and one write port and a
// registered read, and the walk reads one slot per cycle, unless stalled,
// while writing back the previous one. A fired result is held in a one-deep
// pending register until the next firing or the end of the walk decides its
// last flag. Every result waits for the result register to be free, so a slow
// result consumer stalls the walk and the single-slot requests cycle for
// cycle. The result register lets the next request be accepted while the
// final result still waits.
// The slot table needs no clearing pass after reset; valid and run bits
// are flip-flops cleared by reset.

module periodic_task_tick_scheduler #(
  parameter int NUM_TASKS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptts_in_if.sink    in_chan,
  ptts_out_if.source out_chan
);
  import ptts_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accepts a request only when idle, then runs it to completion
  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table, tick walk and result register
  ptts_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_chan.req_type),
    .in_slot        (in_chan.slot),
    .in_period      (in_chan.period),
    .in_first_delay (in_chan.first_delay),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_status     (out_chan.status),
    .out_task_index (out_chan.task_index),
    .out_last       (out_chan.last)
  );

endmodule

`default_nettype wire
